[hdl/pvbe_pkg.sv]
// Package: shared types, codes and helpers for the posting list vbyte encoder.
`timescale 1ns / 1ps
`default_nettype none
package pvbe_pkg;

  localparam int GAP_MAX_W = 64;
  localparam int GROUP_MAX = 10;
  localparam int GRP_W     = 4;

  typedef enum logic {
    FUNC_OCCUR = 1'b0,
    FUNC_FLUSH = 1'b1
  } func_t;

  typedef struct packed {
    logic        func;
    logic [31:0] doc_id;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_count;
    logic       last;
  } out_word_t;

  // work handed from front to back
  typedef struct packed {
    logic                 has_count;
    logic [7:0]           count;
    logic                 has_gap;
    logic [GAP_MAX_W-1:0] gap;
  } cmd_t;

  // index of the most significant nonzero 7-bit group, 0 when gap < 128
  function automatic logic [GRP_W-1:0] grp_top(logic [GAP_MAX_W-1:0] gap);
    logic [GRP_W-1:0] r;
    r = '0;
    for (int i = 1; i < GROUP_MAX; i++) begin
      if ((gap >> (7 * i)) != '0) r = GRP_W'(i);
    end
    return r;
  endfunction

  function automatic logic [6:0] gap_chunk(logic [GAP_MAX_W-1:0] gap,
                                           logic [GRP_W-1:0] idx);
    logic [6:0] r;
    r = '0;
    for (int i = 0; i < GROUP_MAX; i++) begin
      if (idx == GRP_W'(i)) r = 7'(gap >> (7 * i));
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[hdl/pvbe_front.sv]
// Front end: takes input words, tracks the open document, issues byte commands.
`timescale 1ns / 1ps
`default_nettype none
module pvbe_front #(
  parameter int ID_WIDTH    = 32,
  parameter int COUNT_LIMIT = 255
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire pvbe_pkg::in_word_t in_item,
  output logic                  cmd_push,
  output pvbe_pkg::cmd_t        cmd
);

  logic [ID_WIDTH-1:0] last_doc, last_doc_next;
  logic                have_doc, have_doc_next;
  logic [7:0]          count, count_next;
  logic [ID_WIDTH-1:0] id;
  logic [ID_WIDTH-1:0] gap;
  logic                is_flush;

  assign id       = ID_WIDTH'(64'(in_item.doc_id));
  assign gap      = id - last_doc;
  assign is_flush = (in_item.func == pvbe_pkg::FUNC_FLUSH);

  always_comb begin
    last_doc_next = last_doc;
    have_doc_next = have_doc;
    count_next    = count;
    cmd_push      = 1'b0;
    cmd.has_count = have_doc;
    cmd.count     = count;
    cmd.has_gap   = 1'b0;
    cmd.gap       = pvbe_pkg::GAP_MAX_W'(gap);
    if (accept) begin
      priority if (is_flush) begin
        cmd_push      = have_doc;
        last_doc_next = '0;
        have_doc_next = 1'b0;
        count_next    = '0;
      end else if (have_doc && id == last_doc) begin
        if (count < 8'(COUNT_LIMIT)) count_next = count + 8'd1;
      end else begin
        cmd_push      = 1'b1;
        cmd.has_gap   = 1'b1;
        last_doc_next = id;
        have_doc_next = 1'b1;
        count_next    = 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_doc <= '0;
      have_doc <= 1'b0;
      count    <= '0;
    end else begin
      last_doc <= last_doc_next;
      have_doc <= have_doc_next;
      count    <= count_next;
    end
  end

endmodule
`default_nettype wire

[hdl/pvbe_cmd_queue.sv]
// Short command queue between front and back.
`timescale 1ns / 1ps
`default_nettype none
module pvbe_cmd_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr_en,
  input  wire pvbe_pkg::cmd_t wr_data,
  output logic                full,
  input  wire logic           rd_en,
  output pvbe_pkg::cmd_t      rd_data,
  output logic                not_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pvbe_pkg::cmd_t mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] fill;

  assign full      = (fill == CW'(DEPTH));
  assign not_empty = (fill != '0);
  assign rd_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      if (rd_en) rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      unique case ({wr_en, rd_en})
        2'b10:   fill <= fill + CW'(1);
        2'b01:   fill <= fill - CW'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

[hdl/pvbe_back.sv]
// Back end: serializes count and gap bytes into the output register.
`timescale 1ns / 1ps
`default_nettype none
module pvbe_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire pvbe_pkg::cmd_t cmd,
  input  wire logic           cmd_avail,
  output logic                cmd_pop,
  output logic                empty,
  input  wire logic           pop,
  output pvbe_pkg::out_word_t out_item
);

  logic                          active;
  logic                          cnt_pend;
  logic                          gap_pend;
  logic [7:0]                    count;
  logic [pvbe_pkg::GAP_MAX_W-1:0] gap;
  logic [pvbe_pkg::GRP_W-1:0]    grp;
  logic                          out_vld;

  logic                out_free;
  logic                emit;
  logic                cur_last;
  pvbe_pkg::out_word_t cur;

  assign out_free = !out_vld || pop;
  assign emit     = active && out_free;
  assign cur_last = cnt_pend ? !gap_pend : (grp == '0);
  assign cmd_pop  = cmd_avail && (!active || (emit && cur_last));
  assign empty    = !out_vld;

  always_comb begin
    cur.is_count = cnt_pend;
    cur.last     = cur_last;
    if (cnt_pend) cur.out_byte = count;
    else          cur.out_byte = {grp == '0, pvbe_pkg::gap_chunk(gap, grp)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      cnt_pend <= 1'b0;
      gap_pend <= 1'b0;
      out_vld  <= 1'b0;
    end else begin
      out_vld <= emit || (out_vld && !pop);
      if (cmd_pop) begin
        active   <= 1'b1;
        cnt_pend <= cmd.has_count;
        gap_pend <= cmd.has_gap;
      end else if (emit) begin
        if (cnt_pend) begin
          cnt_pend <= 1'b0;
          if (!gap_pend) active <= 1'b0;
        end else if (grp == '0) begin
          active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) out_item <= cur;
    if (cmd_pop) begin
      count <= cmd.count;
      gap   <= cmd.gap;
      grp   <= pvbe_pkg::grp_top(cmd.gap);
    end else if (emit && !cnt_pend && grp != '0) begin
      grp <= grp - pvbe_pkg::GRP_W'(1);
    end
  end

endmodule
`default_nettype wire

[hdl/posting_list_vbyte_encoder_unit.sv]
// Top level: posting list delta-gap variable-byte encoder.
//
// Input channel: push/full carries one word {func, doc_id}. func occurrence
// adds a document id, func flush ends the list. Output channel: empty/pop
// presents one word {out_byte, is_count, last} at a time, oldest first.
// A repeated id only bumps the open document's count and makes no output.
// A new id makes the previous document's count byte (if any) followed by
// 1 to 10 gap bytes, most significant 7-bit group first, bit 7 set on the
// final gap byte. Flush makes the pending count byte, if any.
// A word's command is written into the queue and popped into the back end's
// registers, which then load its first byte into the output register.
// Throughput: one input word per cycle while the command queue has room;
// output drains one byte per cycle while pop is held high. The back end's
// one-byte-per-cycle serializer sets the sustained rate.
// Reset (synchronous, rst high) clears the open document, last id and the
// queue; no clearing pass. When pop stays low the output register holds,
// the back end stops, and full rises once QUEUE_DEPTH commands wait.
`timescale 1ns / 1ps
`default_nettype none
module posting_list_vbyte_encoder_unit #(
  parameter int ID_WIDTH    = 32,
  parameter int COUNT_LIMIT = 255,
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire pvbe_pkg::in_word_t in_item,
  output logic                    empty,
  input  wire logic               pop,
  output pvbe_pkg::out_word_t     out_item
);

  logic           accept;
  logic           cmd_push;
  pvbe_pkg::cmd_t cmd_in;
  pvbe_pkg::cmd_t cmd_head;
  logic           cmd_avail;
  logic           cmd_pop;

  assign accept = push && !full;

  pvbe_front #(
    .ID_WIDTH    (ID_WIDTH),
    .COUNT_LIMIT (COUNT_LIMIT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .in_item  (in_item),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  pvbe_cmd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (cmd_push),
    .wr_data   (cmd_in),
    .full      (full),
    .rd_en     (cmd_pop),
    .rd_data   (cmd_head),
    .not_empty (cmd_avail)
  );

  pvbe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_head),
    .cmd_avail (cmd_avail),
    .cmd_pop   (cmd_pop),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

[verif/tb_posting_list_vbyte_encoder_unit.sv]
// Testbench for posting_list_vbyte_encoder_unit: directed table plus random lists, self-checked.
`timescale 1ns / 1ps
module tb_posting_list_vbyte_encoder_unit;

  localparam int PREDICT        = -1;
  localparam int COUNT_MAX      = 255;
  localparam int ITEM_TARGET    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 20;

  typedef struct {
    pvbe_pkg::in_word_t  w;
    int                  n_typed;
    pvbe_pkg::out_word_t t0;
    pvbe_pkg::out_word_t t1;
  } stim_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                push = 1'b0;
  logic                pop = 1'b0;
  pvbe_pkg::in_word_t  in_item = '0;
  logic                full;
  logic                empty;
  pvbe_pkg::out_word_t out_item;

  stim_t               stim_q[$];
  pvbe_pkg::out_word_t expected_bytes[$];
  pvbe_pkg::out_word_t encoded[$];
  int        next_word = 0;
  int        burst_left = 0;
  int        idle_left = 0;
  int        rx_mode = 0;
  int        mode_left = 0;
  int        cycle_cnt = 0;
  int        quiet_cycles = 0;
  int        errors = 0;

  // encoder state
  logic [31:0] last_id = '0;
  logic        doc_open = 1'b0;
  logic [7:0]  doc_count = '0;

  stim_t directed_rows [17] = '{
    '{{pvbe_pkg::FUNC_OCCUR, 32'd0},         1,       {8'h80, 1'b0, 1'b1}, '0},
    '{{pvbe_pkg::FUNC_OCCUR, 32'd0},         0,       '0, '0},
    '{{pvbe_pkg::FUNC_FLUSH, 32'd0},         1,       {8'h02, 1'b1, 1'b1}, '0},
    '{{pvbe_pkg::FUNC_FLUSH, 32'hFFFF_FFFF}, 0,       '0, '0},
    '{{pvbe_pkg::FUNC_OCCUR, 32'hFFFF_FFFF}, PREDICT, '0, '0},
    '{{pvbe_pkg::FUNC_OCCUR, 32'd0},         2,       {8'h01, 1'b1, 1'b0},
      {8'h81, 1'b0, 1'b1}},
    '{{pvbe_pkg::FUNC_OCCUR, 32'd127},       2,       {8'h01, 1'b1, 1'b0},
      {8'hFF, 1'b0, 1'b1}},
    '{{pvbe_pkg::FUNC_OCCUR, 32'd255},       PREDICT, '0, '0},
    '{{pvbe_pkg::FUNC_OCCUR, 32'd255},       0,       '0, '0},
    '{{pvbe_pkg::FUNC_OCCUR, 32'd100},       PREDICT, '0, '0},
    '{{pvbe_pkg::FUNC_OCCUR, 32'h8000_0000}, PREDICT, '0, '0},
    '{{pvbe_pkg::FUNC_OCCUR, 32'h7FFF_FFFF}, PREDICT, '0, '0},
    '{{pvbe_pkg::FUNC_OCCUR, 32'h5555_5555}, PREDICT, '0, '0},
    '{{pvbe_pkg::FUNC_OCCUR, 32'hAAAA_AAAA}, PREDICT, '0, '0},
    '{{pvbe_pkg::FUNC_FLUSH, 32'h1234_5678}, PREDICT, '0, '0},
    '{{pvbe_pkg::FUNC_OCCUR, 32'd5},         PREDICT, '0, '0},
    '{{pvbe_pkg::FUNC_FLUSH, 32'd0},         1,       {8'h01, 1'b1, 1'b1}, '0}
  };

  posting_list_vbyte_encoder_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic void encode_item(pvbe_pkg::in_word_t w);
    logic [31:0]         gap;
    pvbe_pkg::out_word_t wd;
    int                  top;
    encoded.delete();
    if (w.func == pvbe_pkg::FUNC_FLUSH) begin
      if (doc_open) begin
        wd = {doc_count, 1'b1, 1'b0};
        encoded.push_back(wd);
      end
      last_id   = '0;
      doc_open  = 1'b0;
      doc_count = '0;
    end else if (doc_open && w.doc_id == last_id) begin
      if (doc_count < COUNT_MAX) doc_count++;
    end else begin
      if (doc_open) begin
        wd = {doc_count, 1'b1, 1'b0};
        encoded.push_back(wd);
      end
      gap = w.doc_id - last_id;
      top = 0;
      for (int i = 1; i < 5; i++) begin
        if ((gap >> (7 * i)) != '0) top = i;
      end
      for (int g = top; g >= 0; g--) begin
        wd = {g == 0, 7'(gap >> (7 * g)), 1'b0, 1'b0};
        encoded.push_back(wd);
      end
      last_id   = w.doc_id;
      doc_open  = 1'b1;
      doc_count = 8'd1;
    end
    if (encoded.size() > 0) encoded[encoded.size() - 1].last = 1'b1;
  endfunction

  // sender: bursts of words with random gaps
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        encode_item(stim_q[next_word].w);
        if (stim_q[next_word].n_typed == PREDICT) begin
          foreach (encoded[i]) expected_bytes.push_back(encoded[i]);
        end else begin
          if (stim_q[next_word].n_typed > 0) expected_bytes.push_back(stim_q[next_word].t0);
          if (stim_q[next_word].n_typed > 1) expected_bytes.push_back(stim_q[next_word].t1);
        end
        next_word++;
      end
      if ((push && !full) || !push) begin
        if (idle_left > 0) begin
          idle_left--;
          push <= 1'b0;
        end else if (next_word < stim_q.size()) begin
          push    <= 1'b1;
          in_item <= stim_q[next_word].w;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            idle_left  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern switches mode now and then; checks each popped word
  always @(posedge clk) begin
    pvbe_pkg::out_word_t e;
    cycle_cnt++;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected word, expected none actual %h", $time, out_item);
          errors++;
        end else begin
          e = expected_bytes.pop_front();
          if (out_item.out_byte !== e.out_byte) begin
            $display("%0t: out_byte expected %h actual %h", $time, e.out_byte,
                     out_item.out_byte);
            errors++;
          end
          if (out_item.is_count !== e.is_count) begin
            $display("%0t: is_count expected %b actual %b", $time, e.is_count,
                     out_item.is_count);
            errors++;
          end
          if (out_item.last !== e.last) begin
            $display("%0t: last expected %b actual %b", $time, e.last, out_item.last);
            errors++;
          end
        end
      end
      if (mode_left == 0) begin
        rx_mode   = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 200);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        0: pop <= 1'b1;
        1: pop <= 1'($urandom_range(0, 1));
        2: pop <= (cycle_cnt % 4) != 0;
        default: pop <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    stim_t       s;
    int          n_items;
    int          n_docs;
    int          reps;
    int          w;
    logic [31:0] cur_id;
    logic [31:0] gap;
    bit          sat_done;
    foreach (directed_rows[i]) stim_q.push_back(directed_rows[i]);
    s.n_typed = PREDICT;
    s.t0      = '0;
    s.t1      = '0;
    n_items   = 0;
    sat_done  = 1'b0;
    while (n_items < ITEM_TARGET) begin
      if ($urandom_range(0, 9) == 0) begin
        // noise
        s.w = {1'($urandom), 32'($urandom)};
        stim_q.push_back(s);
        n_items++;
      end else begin
        n_docs = $urandom_range(1, 12);
        cur_id = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 300)) : 32'($urandom);
        for (int d = 0; d < n_docs; d++) begin
          w   = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 32) : $urandom_range(1, 8);
          gap = 32'($urandom) & (32'hFFFF_FFFF >> (32 - w));
          if (d > 0) cur_id = cur_id + gap;
          // one long run drives the count into saturation
          if (!sat_done) begin
            reps     = $urandom_range(256, 264);
            sat_done = 1'b1;
          end else begin
            reps = $urandom_range(1, 4);
          end
          s.w = {pvbe_pkg::FUNC_OCCUR, cur_id};
          repeat (reps) stim_q.push_back(s);
          n_items += reps;
        end
        // most lists end cleanly; some run on, some flush twice
        if ($urandom_range(0, 8) != 0) begin
          s.w = {pvbe_pkg::FUNC_FLUSH, 32'($urandom)};
          stim_q.push_back(s);
          n_items++;
          if ($urandom_range(0, 9) == 0) begin
            stim_q.push_back(s);
            n_items++;
          end
        end
      end
    end
    s.w = {pvbe_pkg::FUNC_FLUSH, 32'd0};
    stim_q.push_back(s);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    while (next_word < stim_q.size()) @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[posting_list_vbyte_encoder_unit.f]
hdl/pvbe_pkg.sv
hdl/pvbe_front.sv
hdl/pvbe_cmd_queue.sv
hdl/pvbe_back.sv
hdl/posting_list_vbyte_encoder_unit.sv
verif/tb_posting_list_vbyte_encoder_unit.sv
